### src/sap_pkg.sv
// Shared types, constants and saturation helpers of the stereo allpass phaser.
package sap_pkg;

   // Port payload types
   typedef logic signed [15:0] sample_type;
   typedef logic [2:0]         csr_index_type;
   typedef logic [23:0]        csr_data_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_ENABLED        = 3'd0,
      CSR_DEPTH          = 3'd1,
      CSR_LFO_INCREMENT  = 3'd2,
      CSR_FEEDBACK_GAIN  = 3'd3,
      CSR_MAX_WET_MIX    = 3'd4,
      CSR_LOG2_NOTCH_MIN = 3'd5,
      CSR_LOG2_NOTCH_MAX = 3'd6,
      CSR_RAMP_STEP      = 3'd7
   } csr_reg_type;

   // Unity in Q1.16 and Q30
   localparam logic [16:0] UNITY_Q16 = 17'd65536;
   localparam logic [30:0] Q30       = 31'h4000_0000;

   // Quarter-wave sine polynomial, Horner order
   localparam logic [31:0] QS_C0 = 32'd172272;
   localparam logic [31:0] QS_C1 = 32'd5026995;
   localparam logic [31:0] QS_C2 = 32'd85569306;
   localparam logic [31:0] QS_C3 = 32'd693598669;
   localparam logic [31:0] QS_C4 = 32'd1686629713;

   // 2^x polynomial on the fraction, Horner order
   localparam logic [31:0] EX_C0 = 32'd16377;
   localparam logic [31:0] EX_C1 = 32'd165394;
   localparam logic [31:0] EX_C2 = 32'd1431681;
   localparam logic [31:0] EX_C3 = 32'd10327388;
   localparam logic [31:0] EX_C4 = 32'd59597083;
   localparam logic [31:0] EX_C5 = 32'd257941248;
   localparam logic [31:0] EX_C6 = 32'd744261118;

   // Notch position limits, Q8.16
   localparam logic signed [23:0] L_LO = -24'sd1048576;
   localparam logic signed [23:0] L_HI = -24'sd131072;

   // Reset phase of the second channel, a quarter cycle ahead
   localparam logic [31:0] PHASE_QUARTER = 32'h4000_0000;

   localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] S24_MIN = 24'sh800000;
   localparam logic signed [15:0] S16_MAX = 16'sh7FFF;
   localparam logic signed [15:0] S16_MIN = 16'sh8000;

   // Saturate to Q4.20
   function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
      logic signed [23:0] r;
      if (v > 27'(S24_MAX)) begin
         r = S24_MAX;
      end else if (v < 27'(S24_MIN)) begin
         r = S24_MIN;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   // Saturate to Q1.15
   function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
      logic signed [15:0] r;
      if (v > 22'(S16_MAX)) begin
         r = S16_MAX;
      end else if (v < 22'(S16_MIN)) begin
         r = S16_MIN;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

### src/sap_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sap_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

### src/stereo_allpass_phaser.sv
// Top level of the stereo allpass phaser: sequencer, shared multiplier, divider, stage RAM.
//
// Stereo phaser: each request carries one sample of channel 0 or 1 and returns one mixed
// sample of the same channel. A per-channel sine LFO sweeps the notch on a log2 scale; the
// allpass coefficient tan(pi/4 - pi*f/fs) is formed in Q1.16 and drives STAGES first-order
// allpass sections in Q4.20 with feedback. The time from acceptance to result is set by the
// single shared 33x33 multiplier that carries every product in turn, the 18-step restoring
// divider for the coefficient and the read, multiply and write-back of each stage through
// the stage RAM. A bypassed request (disabled, or depth zero) passes the dry sample and
// clears all filter and LFO state at once. A result waits in its output register while
// the next request is accepted.
module stereo_allpass_phaser #(
   parameter int STAGES   = 4,
   parameter int CHANNELS = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_channel,
   input  sap_pkg::sample_type    req_sample_in,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_channel_out,
   output sap_pkg::sample_type    rsp_sample_out,
   input  logic                   csr_wr_en,
   input  sap_pkg::csr_index_type csr_index,
   input  sap_pkg::csr_data_type  csr_wr_data
);
   import sap_pkg::*;

   localparam int NENT = CHANNELS * STAGES;
   localparam int AW   = (NENT > 1) ? $clog2(NENT) : 1;
   localparam int KW   = (STAGES > 1) ? $clog2(STAGES) : 1;

   typedef enum logic [5:0] {
      S_IDLE, S_TGT, S_RAMP,
      S_QSQ, S_QH0, S_QH1, S_QH2, S_QH3, S_QH4, S_QEND,
      S_LFO, S_SCALE, S_NOTCH,
      S_EX0, S_EX1, S_EX2, S_EX3, S_EX4, S_EX5, S_EX6, S_EX7,
      S_DPREP, S_DIV, S_DFIN,
      S_FB, S_FBX, S_RD, S_MUL, S_WR, S_MIX0, S_MIX1, S_DONE
   } state_type;

   typedef enum logic [1:0] {RET_LFO, RET_SIN, RET_COS} ret_type;

   // Configuration registers
   logic               enabled_ff;
   logic [16:0]        depth_ff;
   logic [23:0]        lfo_inc_ff;
   logic signed [15:0] fb_gain_ff;
   logic [16:0]        max_wet_ff;
   logic signed [20:0] notch_min_ff;
   logic signed [20:0] notch_max_ff;
   logic [16:0]        ramp_step_ff;

   // Sequencer and datapath registers
   state_type          state_ff;
   ret_type            ret_ff;
   logic               ch_ff;
   logic signed [15:0] dry_ff;
   logic signed [65:0] prod_ff;
   logic [30:0]        qs_x_ff;
   logic [30:0]        qs_x2_ff;
   logic [31:0]        ph_ff;
   logic signed [17:0] lfo_ff;
   logic [4:0]         n_ff;
   logic [15:0]        frac_ff;
   logic [30:0]        xt_ff;
   logic [30:0]        sn_ff;
   logic [30:0]        cs_ff;
   logic [31:0]        den_ff;
   logic [31:0]        rem_ff;
   logic [17:0]        dvd_ff;
   logic [17:0]        q_ff;
   logic [4:0]         cnt_ff;
   logic [16:0]        d_ff;
   logic signed [23:0] x_ff;
   logic signed [23:0] prev_in_ff;
   logic [KW-1:0]      k_ff;
   logic signed [15:0] res_ff;
   logic               rsp_valid_ff;
   logic               rsp_ch_ff;
   logic signed [15:0] rsp_sample_ff;

   // Per-channel and global effect state
   logic [31:0]        lfo_phase_ff [CHANNELS];
   logic signed [23:0] fb_val_ff    [CHANNELS];
   logic [16:0]        wet_ff;
   logic               st_valid_ff  [NENT];

   // Combinational values
   logic [16:0]        dep;
   logic [16:0]        mwm;
   logic               chi;
   logic               bypass;
   logic [AW-1:0]      st_addr;
   logic [47:0]        ram_rdata;
   logic [47:0]        ram_wdata;
   logic               ram_wr;
   logic               ram_rd;
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] prod_in;
   logic [31:0]        p30;
   logic [31:0]        qs_c;
   logic [31:0]        qs_t;
   logic [30:0]        qs_res;
   logic [16:0]        lfo_mag;
   logic signed [17:0] s_full;
   logic [16:0]        s_val;
   logic signed [21:0] notch_diff;
   logic signed [23:0] l_sum;
   logic signed [23:0] l_cl;
   logic [21:0]        lneg;
   logic [21:0]        n_wide;
   logic [21:0]        frac_wide;
   logic [31:0]        ex_c;
   logic [31:0]        ex_t;
   logic [30:0]        xt_new;
   logic [30:0]        num;
   logic [31:0]        den;
   logic [47:0]        dvd_full;
   logic [32:0]        trial;
   logic               ge;
   logic [16:0]        target;
   logic [18:0]        wet_up;
   logic signed [18:0] wet_dn;
   logic signed [20:0] dry20;
   logic signed [23:0] x_new;
   logic signed [23:0] st_prev_in;
   logic signed [23:0] st_prev_out;
   logic signed [24:0] st_diff;
   logic signed [23:0] y_new;
   logic signed [24:0] mix_diff;
   logic signed [26:0] mix_o;
   logic signed [21:0] mix_r;

   assign dep       = (depth_ff > UNITY_Q16) ? UNITY_Q16 : depth_ff;
   assign mwm       = (max_wet_ff > UNITY_Q16) ? UNITY_Q16 : max_wet_ff;
   assign bypass    = !enabled_ff || (depth_ff == '0);
   assign chi       = (CHANNELS > 1) ? ch_ff : 1'b0;
   assign st_addr   = ch_ff ? (AW'(STAGES) + AW'(k_ff)) : AW'(k_ff);
   assign dry20     = {dry_ff[15], dry_ff[15:0], 4'b0} <<< 1;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_ch_ff;
   assign rsp_sample_out  = rsp_sample_ff;

   // Shared multiplier, product registered
   assign prod_in = mul_a * mul_b;

   // Previous stage values, cleared entries read as zero
   assign st_prev_in  = st_valid_ff[st_addr] ? $signed(ram_rdata[47:24]) : '0;
   assign st_prev_out = st_valid_ff[st_addr] ? $signed(ram_rdata[23:0]) : '0;

   assign ram_rd    = (state_ff == S_RD);
   assign ram_wr    = (state_ff == S_WR);
   assign ram_wdata = {x_ff, y_new};

   sap_ram #(
      .WIDTH (48),
      .DEPTH (NENT)
   ) u_stage_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (st_addr),
      .wr_data (ram_wdata),
      .rd_en   (ram_rd),
      .rd_addr (st_addr),
      .rd_data (ram_rdata)
   );

   // Datapath arithmetic around the multiplier
   always_comb begin
      p30 = prod_ff[61:30];
      case (state_ff)
         S_QH1:   qs_c = QS_C1;
         S_QH2:   qs_c = QS_C2;
         S_QH3:   qs_c = QS_C3;
         S_QH4:   qs_c = QS_C4;
         default: qs_c = '0;
      endcase
      qs_t    = qs_c - p30;
      qs_res  = (p30 > 32'(Q30)) ? Q30 : p30[30:0];
      lfo_mag = qs_res[30:14];

      s_full     = 18'(prod_ff >>> 17) + 18'sd32768;
      s_val      = s_full[16:0];
      notch_diff = 22'(notch_max_ff) - 22'(notch_min_ff);

      l_sum = 24'(notch_min_ff) + 24'(prod_ff >>> 16);
      if (l_sum < L_LO) begin
         l_cl = L_LO;
      end else if (l_sum > L_HI) begin
         l_cl = L_HI;
      end else begin
         l_cl = l_sum;
      end
      lneg      = 22'(-l_cl);
      n_wide    = (lneg + 22'd65535) >> 16;
      frac_wide = (n_wide << 16) - lneg;

      case (state_ff)
         S_EX1:   ex_c = EX_C1;
         S_EX2:   ex_c = EX_C2;
         S_EX3:   ex_c = EX_C3;
         S_EX4:   ex_c = EX_C4;
         S_EX5:   ex_c = EX_C5;
         S_EX6:   ex_c = EX_C6;
         default: ex_c = 32'(Q30);
      endcase
      ex_t   = ex_c + prod_ff[47:16];
      xt_new = 31'(ex_t >> (n_ff - 5'd1));

      num = (cs_ff >= sn_ff) ? (cs_ff - sn_ff) : '0;
      den = 32'(cs_ff) + 32'(sn_ff);
      if (den == '0) begin
         den = 32'd1;
      end
      dvd_full = (48'(num) << 16) + 48'(den >> 1);
      trial    = {rem_ff, dvd_ff[17]};
      ge       = (trial >= {1'b0, den_ff});

      target = prod_ff[32:16];
      wet_up = 19'(wet_ff) + 19'(ramp_step_ff);
      wet_dn = $signed(19'(wet_ff)) - $signed(19'(ramp_step_ff));

      x_new    = sat24(27'(dry20) + 27'(prod_ff >>> 15));
      st_diff  = 25'(st_prev_out) - 25'(x_ff);
      y_new    = sat24(27'(prev_in_ff) + 27'(prod_ff >>> 16));
      mix_diff = 25'(x_ff) - 25'(dry20);
      mix_o    = 27'(dry20) + 27'(prod_ff >>> 16);
      mix_r    = 22'((mix_o + 27'sd16) >>> 5);

      // Select multiplier operands for this step
      case (state_ff)
         S_TGT: begin
            mul_a = $signed(33'(dep));
            mul_b = $signed(33'(mwm));
         end
         S_QSQ: begin
            mul_a = $signed(33'(qs_x_ff));
            mul_b = $signed(33'(qs_x_ff));
         end
         S_QH0: begin
            mul_a = $signed(33'(p30[30:0]));
            mul_b = $signed(33'(QS_C0));
         end
         S_QH1, S_QH2, S_QH3: begin
            mul_a = $signed(33'(qs_x2_ff));
            mul_b = $signed(33'(qs_t));
         end
         S_QH4: begin
            mul_a = $signed(33'(qs_x_ff));
            mul_b = $signed(33'(qs_t));
         end
         S_LFO: begin
            mul_a = 33'(lfo_ff);
            mul_b = $signed(33'(dep));
         end
         S_SCALE: begin
            mul_a = 33'(notch_diff);
            mul_b = $signed(33'(s_val));
         end
         S_EX0: begin
            mul_a = $signed(33'(frac_ff));
            mul_b = $signed(33'(EX_C0));
         end
         S_EX1, S_EX2, S_EX3, S_EX4, S_EX5, S_EX6: begin
            mul_a = $signed(33'(frac_ff));
            mul_b = $signed(33'(ex_t));
         end
         S_FB: begin
            mul_a = 33'(fb_gain_ff);
            mul_b = 33'(fb_val_ff[chi]);
         end
         S_MUL: begin
            mul_a = $signed(33'(d_ff));
            mul_b = 33'(st_diff);
         end
         S_MIX0: begin
            mul_a = 33'(mix_diff);
            mul_b = $signed(33'(wet_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         depth_ff     <= '0;
         lfo_inc_ff   <= '0;
         fb_gain_ff   <= '0;
         max_wet_ff   <= UNITY_Q16;
         notch_min_ff <= -21'sd655360;
         notch_max_ff <= -21'sd262144;
         ramp_step_ff <= 17'd340;
      end else if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            CSR_ENABLED:        enabled_ff   <= csr_wr_data[0];
            CSR_DEPTH:          depth_ff     <= csr_wr_data[16:0];
            CSR_LFO_INCREMENT:  lfo_inc_ff   <= csr_wr_data;
            CSR_FEEDBACK_GAIN:  fb_gain_ff   <= $signed(csr_wr_data[15:0]);
            CSR_MAX_WET_MIX:    max_wet_ff   <= csr_wr_data[16:0];
            CSR_LOG2_NOTCH_MIN: notch_min_ff <= $signed(csr_wr_data[20:0]);
            CSR_LOG2_NOTCH_MAX: notch_max_ff <= $signed(csr_wr_data[20:0]);
            CSR_RAMP_STEP:      ramp_step_ff <= csr_wr_data[16:0];
            default: ;
         endcase
      end
   end

   // Sequencer, datapath registers and output register
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wet_ff       <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            lfo_phase_ff[c] <= (c == 1) ? PHASE_QUARTER : '0;
            fb_val_ff[c]    <= '0;
         end
         for (int e = 0; e < NENT; e++) begin
            st_valid_ff[e] <= 1'b0;
         end
      end else begin
         // Drop the result once taken
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  ch_ff  <= req_channel;
                  dry_ff <= req_sample_in;
                  if (bypass) begin
                     // Pass dry and clear all effect state
                     res_ff <= req_sample_in;
                     wet_ff <= '0;
                     for (int c = 0; c < CHANNELS; c++) begin
                        lfo_phase_ff[c] <= (c == 1) ? PHASE_QUARTER : '0;
                        fb_val_ff[c]    <= '0;
                     end
                     for (int e = 0; e < NENT; e++) begin
                        st_valid_ff[e] <= 1'b0;
                     end
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_TGT;
                  end
               end
            end
            S_TGT: state_ff <= S_RAMP;
            S_RAMP: begin
               // Advance the wet mix ramp on left requests
               if (!ch_ff) begin
                  if (19'(wet_ff) < 19'(target)) begin
                     wet_ff <= (wet_up > 19'(target)) ? target : wet_up[16:0];
                  end else if (wet_ff > target) begin
                     wet_ff <= (wet_dn < $signed(19'(target))) ? target : wet_dn[16:0];
                  end
               end
               if ((CHANNELS == 1) && ch_ff) begin
                  res_ff   <= dry_ff;
                  state_ff <= S_DONE;
               end else begin
                  ph_ff    <= lfo_phase_ff[chi];
                  qs_x_ff  <= lfo_phase_ff[chi][30] ?
                              (Q30 - 31'(lfo_phase_ff[chi][29:0])) :
                              31'(lfo_phase_ff[chi][29:0]);
                  ret_ff   <= RET_LFO;
                  state_ff <= S_QSQ;
               end
            end
            S_QSQ: state_ff <= S_QH0;
            S_QH0: begin
               qs_x2_ff <= p30[30:0];
               state_ff <= S_QH1;
            end
            S_QH1: state_ff <= S_QH2;
            S_QH2: state_ff <= S_QH3;
            S_QH3: state_ff <= S_QH4;
            S_QH4: state_ff <= S_QEND;
            S_QEND: begin
               // Hand the sine back to the step that asked for it
               case (ret_ff)
                  RET_LFO: begin
                     lfo_ff   <= ph_ff[31] ? -$signed(18'(lfo_mag)) : $signed(18'(lfo_mag));
                     state_ff <= S_LFO;
                  end
                  RET_SIN: begin
                     sn_ff    <= qs_res;
                     qs_x_ff  <= Q30 - xt_ff;
                     ret_ff   <= RET_COS;
                     state_ff <= S_QSQ;
                  end
                  default: begin
                     cs_ff    <= qs_res;
                     state_ff <= S_DPREP;
                  end
               endcase
            end
            S_LFO:   state_ff <= S_SCALE;
            S_SCALE: state_ff <= S_NOTCH;
            S_NOTCH: begin
               n_ff     <= n_wide[4:0];
               frac_ff  <= frac_wide[15:0];
               state_ff <= S_EX0;
            end
            S_EX0: state_ff <= S_EX1;
            S_EX1: state_ff <= S_EX2;
            S_EX2: state_ff <= S_EX3;
            S_EX3: state_ff <= S_EX4;
            S_EX4: state_ff <= S_EX5;
            S_EX5: state_ff <= S_EX6;
            S_EX6: state_ff <= S_EX7;
            S_EX7: begin
               xt_ff    <= xt_new;
               qs_x_ff  <= xt_new;
               ret_ff   <= RET_SIN;
               state_ff <= S_QSQ;
            end
            S_DPREP: begin
               den_ff   <= den;
               rem_ff   <= 32'(dvd_full[47:18]);
               dvd_ff   <= dvd_full[17:0];
               q_ff     <= '0;
               cnt_ff   <= 5'd17;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // One quotient bit per cycle
               rem_ff <= ge ? 32'(trial - {1'b0, den_ff}) : trial[31:0];
               q_ff   <= {q_ff[16:0], ge};
               dvd_ff <= dvd_ff << 1;
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == '0) begin
                  state_ff <= S_DFIN;
               end
            end
            S_DFIN: begin
               d_ff     <= (q_ff > 18'(UNITY_Q16)) ? UNITY_Q16 : q_ff[16:0];
               state_ff <= S_FB;
            end
            S_FB: state_ff <= S_FBX;
            S_FBX: begin
               x_ff     <= x_new;
               k_ff     <= '0;
               state_ff <= S_RD;
            end
            S_RD: state_ff <= S_MUL;
            S_MUL: begin
               prev_in_ff <= st_prev_in;
               state_ff   <= S_WR;
            end
            S_WR: begin
               // Write back the stage and move to the next one
               st_valid_ff[st_addr] <= 1'b1;
               x_ff <= y_new;
               if (k_ff == KW'(STAGES - 1)) begin
                  state_ff <= S_MIX0;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_MIX0: begin
               fb_val_ff[chi] <= x_ff;
               state_ff       <= S_MIX1;
            end
            S_MIX1: begin
               res_ff            <= sat16(mix_r);
               lfo_phase_ff[chi] <= lfo_phase_ff[chi] + 32'(lfo_inc_ff);
               state_ff          <= S_DONE;
            end
            S_DONE: begin
               // Hold until the output register is free
               if (!rsp_valid_ff) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_ch_ff     <= ch_ff;
                  rsp_sample_ff <= res_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### src/sap_checker.sv
// Port-level checks of the stereo allpass phaser and their binding.
module sap_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_channel_out,
   input sap_pkg::sample_type    rsp_sample_out
);

   // One request at a time: no request taken in the cycle after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
                                  && $stable(rsp_channel_out))
      else $error("result changed before it was taken");

   // A result appears only as the sequencer returns to idle
   a_rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result shown while sequencer busy");

   // Reset leaves the block idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind stereo_allpass_phaser sap_checker u_sap_checker (.*);
